@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk while aresetn is high.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ rtl/cbm_pkg.sv @@
package cbm_pkg;

    // Access kinds carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_CPU_READ    = 2'd0,
        CMD_CPU_WRITE   = 2'd1,
        CMD_VIDEO_READ  = 2'd2,
        CMD_VIDEO_WRITE = 2'd3
    } cmd_t;

    // Target memories carried on the output tuser.
    typedef enum logic [2:0] {
        TGT_NONE     = 3'd0,
        TGT_PRG_ROM  = 3'd1,
        TGT_CHR_ROM  = 3'd2,
        TGT_CIRAM    = 3'd3,
        TGT_CART_RAM = 3'd4
    } target_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BOARD_REV   = 2'd0,
        CFG_VERT_MIRROR = 2'd1,
        CFG_CART_RAM    = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    // Board revisions with special behavior; all others act as the base board.
    localparam logic [2:0] REV_CHR_NT   = 3'd1;
    localparam logic [2:0] REV_2K_CHR   = 3'd3;
    localparam logic [2:0] REV_LATCH_NT = 3'd4;

    // Fixed program banks for the upper half of program space.
    localparam logic [3:0] PRG_FIXED_LO = 4'he;
    localparam logic [3:0] PRG_FIXED_HI = 4'hf;

    // Register write decode: address under mask 0xe001.
    localparam logic [15:0] REG_MASK   = 16'he001;
    localparam logic [15:0] REG_SELECT = 16'h8000;
    localparam logic [15:0] REG_LOAD   = 16'h8001;

    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int MAP_W     = 17;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int CHR_BANKS = 6;
    localparam int CFG_DATA_W = 3;

    // Board configuration as one group.
    typedef struct packed {
        logic [2:0] board_revision;
        logic       vertical_mirroring;
        logic       has_cart_ram;
    } cfg_t;

endpackage

@@ rtl/cartridge_bank_mapper.sv @@
// Channel    | Direction | Beat contents
// -----------+-----------+-----------------------------------------------------
// s_axis     | in        | tuser: command; tdata: bus_address, write_data
// m_axis     | out       | tuser: target; tdata: mapped_address
// cfg        | in        | cfg_index (register number), cfg_data (value)
//
// One access enters per cycle while m_axis is not stalled; its result leaves through
// the input register, then the result register, so throughput is one beat a cycle.
// The translation between the two registers is a bank lookup and an address
// merge over the small bank register file.
// aresetn is synchronous and active low; it clears the banks and configuration.
// An m_axis stall holds both stages; s_axis_tready drops only if both are then full.
`include "assert_macros.svh"

module cartridge_bank_mapper (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input access stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [1:0]                       s_axis_tuser,   // [1:0] command
    input  logic [cbm_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [15:0] bus_address,
                                                             // [23:16] write_data
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [2:0]                       m_axis_tuser,   // [2:0] target
    output logic [cbm_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [16:0] mapped_address,
                                                             // [23:17] zero
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cbm_pkg::*;

    // Pipeline control.
    logic                  in_valid_reg;
    logic                  out_valid_reg;
    logic                  advance;

    // Input stage payload.
    cmd_t                  in_cmd_reg;
    logic [ADDR_W-1:0]     in_addr_reg;
    logic [DATA_W-1:0]     in_data_reg;

    // Result stage payload.
    target_t               out_target_reg;
    logic [MAP_W-1:0]      out_addr_reg;
    target_t               target_next;
    logic [MAP_W-1:0]      map_next;

    // Mapper state.
    cfg_t                  cfg_reg;
    logic [2:0]            reg_select_reg;
    logic [2:0]            reg_select_next;
    logic [3:0]            prg_bank_reg [2];
    logic [3:0]            prg_bank_next [2];
    logic [5:0]            chr_bank_reg [CHR_BANKS];
    logic [5:0]            chr_bank_next [CHR_BANKS];
    logic                  nt_latch_reg;
    logic                  nt_latch_next;

    // The input stage moves on whenever the result register is free or emptying.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_target_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - MAP_W){1'b0}}, out_addr_reg};

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg  <= cmd_t'(s_axis_tuser);
            in_addr_reg <= s_axis_tdata[ADDR_W-1:0];
            in_data_reg <= s_axis_tdata[ADDR_W +: DATA_W];
        end
    end

    // Translation and register updates for the access in the input stage.
    always_comb begin
        logic [13:0] v;
        logic [2:0]  slot_idx;
        logic [3:0]  bank;
        logic [5:0]  nt_bank;

        v        = in_addr_reg[13:0];
        slot_idx = 3'd0;
        bank     = 4'd0;
        nt_bank  = 6'd0;

        target_next     = TGT_NONE;
        map_next        = '0;
        reg_select_next = reg_select_reg;
        prg_bank_next   = prg_bank_reg;
        chr_bank_next   = chr_bank_reg;
        nt_latch_next   = nt_latch_reg;

        unique case (in_cmd_reg)
            CMD_CPU_READ: begin
                // Program space: two switchable banks, then the two fixed banks.
                if (in_addr_reg[15]) begin
                    unique case (in_addr_reg[14:13])
                        2'd0:    bank = prg_bank_reg[0];
                        2'd1:    bank = prg_bank_reg[1];
                        2'd2:    bank = PRG_FIXED_LO;
                        default: bank = PRG_FIXED_HI;
                    endcase
                    target_next = TGT_PRG_ROM;
                    map_next    = {bank, in_addr_reg[12:0]};
                end
            end
            CMD_CPU_WRITE: begin
                // Any write in the upper half latches data bit 6.
                if (in_addr_reg[15]) begin
                    nt_latch_next = in_data_reg[6];
                end
                if ((in_addr_reg & REG_MASK) == REG_SELECT) begin
                    reg_select_next = in_data_reg[2:0];
                end else if ((in_addr_reg & REG_MASK) == REG_LOAD) begin
                    unique case (reg_select_reg)
                        3'd0:    chr_bank_next[0] = in_data_reg[6:1];
                        3'd1:    chr_bank_next[1] = in_data_reg[6:1];
                        3'd2:    chr_bank_next[2] = in_data_reg[5:0];
                        3'd3:    chr_bank_next[3] = in_data_reg[5:0];
                        3'd4:    chr_bank_next[4] = in_data_reg[5:0];
                        3'd5:    chr_bank_next[5] = in_data_reg[5:0];
                        3'd6:    prg_bank_next[0] = in_data_reg[3:0];
                        default: prg_bank_next[1] = in_data_reg[3:0];
                    endcase
                end
            end
            default: begin
                if (v[13]) begin
                    // Nametable space.
                    if (!cfg_reg.has_cart_ram) begin
                        target_next = TGT_CIRAM;
                        if (cfg_reg.board_revision == REV_CHR_NT) begin
                            nt_bank  = v[11] ? chr_bank_reg[1] : chr_bank_reg[0];
                            map_next = {6'd0, nt_bank[4], v[9:0]};
                        end else if (cfg_reg.board_revision == REV_LATCH_NT) begin
                            map_next = {6'd0, nt_latch_reg, v[9:0]};
                        end else if (cfg_reg.vertical_mirroring) begin
                            map_next = {6'd0, v[10], v[9:0]};
                        end else begin
                            map_next = {6'd0, v[11], v[9:0]};
                        end
                    end else if (v[11]) begin
                        target_next = TGT_CART_RAM;
                        map_next    = {6'd0, v[10:0]};
                    end else begin
                        target_next = TGT_CIRAM;
                        map_next    = {6'd0, v[10:0]};
                    end
                end else if (in_cmd_reg == CMD_VIDEO_READ) begin
                    // Character space; video writes to it go nowhere.
                    target_next = TGT_CHR_ROM;
                    if (cfg_reg.board_revision == REV_2K_CHR) begin
                        slot_idx = {1'b0, v[12:11]} + 3'd2;
                        map_next = {chr_bank_reg[slot_idx], v[10:0]};
                    end else if (!v[12]) begin
                        map_next = {v[11] ? chr_bank_reg[1] : chr_bank_reg[0], v[10:0]};
                    end else begin
                        slot_idx = {1'b0, v[11:10]} + 3'd2;
                        map_next = {1'b1, chr_bank_reg[slot_idx], v[9:0]};
                    end
                end
            end
        endcase
    end

    // Result register and mapper state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            cfg_reg        <= '0;
            reg_select_reg <= '0;
            prg_bank_reg   <= '{default: '0};
            chr_bank_reg   <= '{default: '0};
            nt_latch_reg   <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg  <= 1'b1;
                reg_select_reg <= reg_select_next;
                prg_bank_reg   <= prg_bank_next;
                chr_bank_reg   <= chr_bank_next;
                nt_latch_reg   <= nt_latch_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_BOARD_REV:   cfg_reg.board_revision     <= cfg_data;
                    CFG_VERT_MIRROR: cfg_reg.vertical_mirroring <= cfg_data[0];
                    CFG_CART_RAM:    cfg_reg.has_cart_ram       <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
        if (advance) begin
            out_target_reg <= target_next;
            out_addr_reg   <= map_next;
        end
    end

    // A result with no target carries a zero address.
    `ASSERT_CLK(a_none_zero_addr, (out_valid_reg && out_target_reg == TGT_NONE) |-> (out_addr_reg == '0), "target none with nonzero address")
    // A CPU write never produces a memory target.
    `ASSERT_CLK(a_write_no_target, (advance && in_cmd_reg == CMD_CPU_WRITE) |=> (out_target_reg == TGT_NONE), "cpu write produced a target")
    // Both stages full and stalled means no new beat is taken.
    `ASSERT_CLK(a_full_backpressure, (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready, "input accepted while pipeline full")
    // Reset leaves no result pending.
    `ASSERT_ALWAYS(a_reset_clears, !$past(aresetn) |-> !m_axis_tvalid, "result valid right after reset")

endmodule
